>>> hw/rtl/qenc_pkg.sv
// shared types and constants of the quadrature encoder channel
package qenc_pkg;

	localparam int unsigned CountW  = 16;
	localparam int unsigned TimeW   = 32;
	localparam int unsigned DivW    = 8;
	localparam int unsigned StepW   = 16;
	localparam int unsigned ApbDataW = 32;
	localparam int unsigned ApbAddrW = 4;

	localparam logic [TimeW-1:0]  PosMax       = 32'h7FFF_FFFF;
	localparam logic [TimeW-1:0]  PeriodReset  = 32'd32767;
	localparam logic [DivW-1:0]   PollDivReset = 8'd2;
	localparam logic [StepW-1:0]  StepReset    = 16'd32;

	// configuration handed from the register block to the datapath
	typedef struct packed {
		logic             full_quadrature;
		logic [DivW-1:0]  poll_divide;
		logic [StepW-1:0] time_step;
	} cfg_t;

endpackage

>>> hw/rtl/qenc_in_if.sv
// sample channel: one tick of encoder levels and a clear request
interface qenc_in_if;
	logic valid;
	logic ready;
	logic a_level;
	logic b_level;
	logic clear_count;

	modport source (output valid, output a_level, output b_level, output clear_count,
		input ready);
	modport sink (input valid, input a_level, input b_level, input clear_count,
		output ready);
endinterface

>>> hw/rtl/qenc_out_if.sv
// reading channel: position count and signed edge period
interface qenc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] position;
	logic signed [31:0] period_reading;

	modport source (output valid, output position, output period_reading, input ready);
	modport sink (input valid, input position, input period_reading, output ready);
endinterface

>>> hw/rtl/qenc_apb_regs.sv
// apb configuration registers of the encoder channel
module qenc_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [qenc_pkg::ApbAddrW-1:0]  paddr,
	input  logic [qenc_pkg::ApbDataW-1:0]  pwdata,
	output logic [qenc_pkg::ApbDataW-1:0]  prdata,
	output logic                           pready,
	output qenc_pkg::cfg_t                 cfg
);

	localparam logic [1:0] RegFullQuad = 2'd0;
	localparam logic [1:0] RegPollDiv  = 2'd1;
	localparam logic [1:0] RegTimeStep = 2'd2;

	qenc_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes, out-of-range addresses ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_quadrature <= 1'b0;
			cfg_q.poll_divide     <= qenc_pkg::PollDivReset;
			cfg_q.time_step       <= qenc_pkg::StepReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				RegFullQuad: cfg_q.full_quadrature <= pwdata[0];
				RegPollDiv:  cfg_q.poll_divide     <= pwdata[qenc_pkg::DivW-1:0];
				RegTimeStep: cfg_q.time_step       <= pwdata[qenc_pkg::StepW-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			RegFullQuad: prdata[0] = cfg_q.full_quadrature;
			RegPollDiv:  prdata[qenc_pkg::DivW-1:0] = cfg_q.poll_divide;
			RegTimeStep: prdata[qenc_pkg::StepW-1:0] = cfg_q.time_step;
			default:     prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/qenc_core.sv
// encoder datapath: input register, decode and period logic, result register
module qenc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  qenc_pkg::cfg_t cfg,
	qenc_in_if.sink        samples,
	qenc_out_if.source     readings
);

	localparam int unsigned TW = qenc_pkg::TimeW;
	localparam int unsigned CW = qenc_pkg::CountW;
	localparam int unsigned DW = qenc_pkg::DivW;

	// input register
	logic s1_valid_q;
	logic a_s1, b_s1, clr_s1;

	// result register
	logic          out_valid_q;
	logic [CW-1:0] position_s2;
	logic [TW-1:0] reading_s2;

	// channel state
	logic [TW-1:0] time_q, last_edge_q, last_period_q;
	logic [CW-1:0] count_q;
	logic          prev_a_q, prev_b_q, prev_bs_q;
	logic [DW-1:0] countdown_q;

	logic s1_fire, out_free;

	// next-state signals
	logic [TW-1:0] time_nx, diff_raw, diff_sat, period_nx, last_edge_nx;
	logic [TW-1:0] elapsed_raw, elapsed, mag_last, reading_nx;
	logic [CW-1:0] count_poll, count_nx;
	logic [DW-1:0] countdown_nx;
	logic          prev_a_nx, prev_b_nx, poll_now, fall, last_pos;

	assign out_free       = !out_valid_q || readings.ready;
	assign s1_fire        = s1_valid_q && out_free;
	assign samples.ready  = !s1_valid_q || out_free;

	assign readings.valid          = out_valid_q;
	assign readings.position       = position_s2;
	assign readings.period_reading = reading_s2;

	// time base
	assign time_nx = time_q + TW'(cfg.time_step);

	// polled x4 decoder, poller runs in both modes
	assign poll_now = (countdown_q == '0);
	always_comb begin
		count_poll   = count_q;
		prev_a_nx    = prev_a_q;
		prev_b_nx    = prev_b_q;
		countdown_nx = countdown_q - DW'(1);
		if (poll_now) begin
			if (cfg.full_quadrature && ((a_s1 != prev_a_q) || (b_s1 != prev_b_q))) begin
				count_poll = (a_s1 ^ prev_b_q) ? count_q - CW'(1) : count_q + CW'(1);
			end
			prev_a_nx    = a_s1;
			prev_b_nx    = b_s1;
			countdown_nx = cfg.poll_divide;
		end
	end

	// falling edge of b: x1 count (in x1 mode only) and period capture
	assign fall     = prev_bs_q && !b_s1;
	assign diff_raw = time_nx - last_edge_q;
	assign diff_sat = diff_raw[TW-1] ? qenc_pkg::PosMax : diff_raw;
	always_comb begin
		count_nx     = count_poll;
		period_nx    = last_period_q;
		last_edge_nx = last_edge_q;
		if (fall) begin
			if (!cfg.full_quadrature) begin
				count_nx = a_s1 ? count_poll + CW'(1) : count_poll - CW'(1);
			end
			period_nx    = a_s1 ? diff_sat : TW'(0) - diff_sat;
			last_edge_nx = time_nx;
		end
	end

	// period reading, elapsed time is zero on an edge tick
	assign elapsed_raw = time_nx - last_edge_q;
	assign elapsed     = fall ? '0 :
		(elapsed_raw[TW-1] ? qenc_pkg::PosMax : elapsed_raw);
	assign mag_last    = last_period_q[TW-1] ? TW'(0) - last_period_q : last_period_q;
	assign last_pos    = (last_period_q != '0) && !last_period_q[TW-1];
	always_comb begin
		if (!fall && (elapsed > mag_last)) begin
			reading_nx = last_pos ? elapsed : TW'(0) - elapsed;
		end else begin
			reading_nx = period_nx;
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (samples.ready) begin
			s1_valid_q <= samples.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			a_s1   <= samples.a_level;
			b_s1   <= samples.b_level;
			clr_s1 <= samples.clear_count;
		end
	end

	// channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q        <= '0;
			last_edge_q   <= '0;
			last_period_q <= qenc_pkg::PeriodReset;
			count_q       <= '0;
			prev_a_q      <= 1'b0;
			prev_b_q      <= 1'b0;
			prev_bs_q     <= 1'b0;
			countdown_q   <= '0;
		end else if (s1_fire) begin
			time_q        <= time_nx;
			last_edge_q   <= last_edge_nx;
			last_period_q <= period_nx;
			count_q       <= clr_s1 ? '0 : count_nx;
			prev_a_q      <= prev_a_nx;
			prev_b_q      <= prev_b_nx;
			prev_bs_q     <= b_s1;
			countdown_q   <= countdown_nx;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			position_s2 <= count_nx;
			reading_s2  <= reading_nx;
		end
	end

endmodule

>>> hw/rtl/quadrature_encoder_with_period.sv
// top level of one quadrature encoder channel with period measurement
// a taken sample request goes through the input register, then the result register offers its reading
// throughput: one sample request per cycle while the result register is not held
// a held result lets the input register take one more request, then stalls the input
// reset (arst_n low, asynchronous): time, count, edge state cleared, period 32767,
// registers back to x1 mode, poll divide 2, time step 32
module quadrature_encoder_with_period (
	input  logic                           clk,
	input  logic                           arst_n,
	qenc_in_if.sink                        samples,
	qenc_out_if.source                     readings,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [qenc_pkg::ApbAddrW-1:0]  paddr,
	input  logic [qenc_pkg::ApbDataW-1:0]  pwdata,
	output logic [qenc_pkg::ApbDataW-1:0]  prdata,
	output logic                           pready
);

	qenc_pkg::cfg_t cfg;

	// configuration registers
	qenc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// decode and period datapath
	qenc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.samples  (samples),
		.readings (readings)
	);

endmodule
